### rtl/fenv_pkg.sv
package fenv_pkg;

    localparam int FRAME_BITS = 24;
    localparam int FADE_BITS  = 20;
    localparam int GAIN_BITS  = 16;
    localparam int GAIN_FRAC  = GAIN_BITS - 1;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;

    localparam int CHAN_W  = 4;
    localparam int BLOCK_W = 13;
    localparam int REQ_W   = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (FRAME_BITS > GAIN_BITS)
        ? ((FRAME_BITS > BLOCK_W) ? FRAME_BITS : BLOCK_W)
        : ((GAIN_BITS > BLOCK_W) ? GAIN_BITS : BLOCK_W);

    localparam int LEN_CMP_W = (FRAME_BITS > BLOCK_W) ? FRAME_BITS : BLOCK_W;
    localparam int FSUM_W    = ((FRAME_BITS > FADE_BITS) ? FRAME_BITS : FADE_BITS) + 1;

    localparam int MUL_W  = (FADE_BITS > GAIN_BITS) ? FADE_BITS : GAIN_BITS;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DEN_W  = (2 * FADE_BITS > FRAME_BITS) ? 2 * FADE_BITS : FRAME_BITS;

    localparam int ITER_MAX = (FRAME_BITS > GAIN_FRAC) ? FRAME_BITS : GAIN_FRAC;
    localparam int ITER_W   = $clog2(ITER_MAX + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUME       = 3'd0,
        CFG_MAIN_LEFT    = 3'd1,
        CFG_MAIN_RIGHT   = 3'd2,
        CFG_AUX_LEFT     = 3'd3,
        CFG_AUX_RIGHT    = 3'd4,
        CFG_TRACK_LENGTH = 3'd5,
        CFG_AUX_LENGTH   = 3'd6,
        CFG_BLOCK_FRAMES = 3'd7
    } cfg_idx_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SQ_CNT,
        ST_SQ_LEN,
        ST_CMP,
        ST_DIV,
        ST_FO_CHK,
        ST_MOD_GO,
        ST_MOD,
        ST_GAIN_A,
        ST_GAIN_B,
        ST_GAIN_C,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0]  volume;
        logic [CHAN_W-1:0]     main_left;
        logic [CHAN_W-1:0]     main_right;
        logic [CHAN_W-1:0]     aux_left;
        logic [CHAN_W-1:0]     aux_right;
        logic [FRAME_BITS-1:0] track_length;
        logic [FRAME_BITS-1:0] aux_length;
        logic [BLOCK_W-1:0]    block_frames;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } div_ctl_t;

    function automatic logic len_ok(input logic [FRAME_BITS-1:0] len,
                                    input logic [BLOCK_W-1:0] blk);
        return (len != '0) && (LEN_CMP_W'(len) >= LEN_CMP_W'(blk));
    endfunction

endpackage

### rtl/fenv_cfg_regs.sv
module fenv_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fenv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fenv_pkg::CFG_DATA_W-1:0]     cfg_data,
    output fenv_pkg::cfg_t                      cfg
);

    fenv_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume       <= fenv_pkg::GAIN_ONE;
            cfg_reg.main_left    <= fenv_pkg::CHAN_W'(0);
            cfg_reg.main_right   <= fenv_pkg::CHAN_W'(1);
            cfg_reg.aux_left     <= fenv_pkg::CHAN_W'(2);
            cfg_reg.aux_right    <= fenv_pkg::CHAN_W'(3);
            cfg_reg.track_length <= '0;
            cfg_reg.aux_length   <= '0;
            cfg_reg.block_frames <= fenv_pkg::BLOCK_W'(256);
        end
        else if (cfg_we)
        begin
            case (fenv_pkg::cfg_idx_t'(cfg_index))
                fenv_pkg::CFG_VOLUME:
                    cfg_reg.volume <= cfg_data[fenv_pkg::GAIN_BITS-1:0];
                fenv_pkg::CFG_MAIN_LEFT:
                    cfg_reg.main_left <= cfg_data[fenv_pkg::CHAN_W-1:0];
                fenv_pkg::CFG_MAIN_RIGHT:
                    cfg_reg.main_right <= cfg_data[fenv_pkg::CHAN_W-1:0];
                fenv_pkg::CFG_AUX_LEFT:
                    cfg_reg.aux_left <= cfg_data[fenv_pkg::CHAN_W-1:0];
                fenv_pkg::CFG_AUX_RIGHT:
                    cfg_reg.aux_right <= cfg_data[fenv_pkg::CHAN_W-1:0];
                fenv_pkg::CFG_TRACK_LENGTH:
                    cfg_reg.track_length <= cfg_data[fenv_pkg::FRAME_BITS-1:0];
                fenv_pkg::CFG_AUX_LENGTH:
                    cfg_reg.aux_length <= cfg_data[fenv_pkg::FRAME_BITS-1:0];
                fenv_pkg::CFG_BLOCK_FRAMES:
                    cfg_reg.block_frames <= cfg_data[fenv_pkg::BLOCK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/fenv_divider.sv
module fenv_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fenv_pkg::div_ctl_t                  ctl,
    input  logic [fenv_pkg::DEN_W-1:0]          rem_init,
    input  logic [fenv_pkg::DEN_W-1:0]          den,
    input  logic [fenv_pkg::FRAME_BITS-1:0]     dividend,
    output logic                                done,
    output logic [fenv_pkg::GAIN_BITS-1:0]      quotient,
    output logic [fenv_pkg::DEN_W-1:0]          remainder
);

    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [fenv_pkg::ITER_W-1:0]       cnt_reg;
    logic [fenv_pkg::ITER_W-1:0]       cnt_next;
    logic [fenv_pkg::DEN_W-1:0]        rem_reg;
    logic [fenv_pkg::DEN_W-1:0]        rem_next;
    logic [fenv_pkg::DEN_W-1:0]        den_reg;
    logic [fenv_pkg::DEN_W-1:0]        den_next;
    logic [fenv_pkg::FRAME_BITS-1:0]   dsh_reg;
    logic [fenv_pkg::FRAME_BITS-1:0]   dsh_next;
    logic [fenv_pkg::GAIN_BITS-1:0]    quo_reg;
    logic [fenv_pkg::GAIN_BITS-1:0]    quo_next;
    logic [fenv_pkg::DEN_W:0]          trial;
    logic [fenv_pkg::DEN_W:0]          diff;
    logic                              fits;

    // shift one dividend bit into the partial remainder and try the subtract
    always_comb
    begin
        trial = {rem_reg, dsh_reg[fenv_pkg::FRAME_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctl.iters;
            rem_next  = rem_init;
            den_next  = den;
            dsh_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[fenv_pkg::DEN_W-1:0] : trial[fenv_pkg::DEN_W-1:0];
            dsh_next = {dsh_reg[fenv_pkg::FRAME_BITS-2:0], 1'b0};
            quo_next = {quo_reg[fenv_pkg::GAIN_BITS-2:0], fits};
            cnt_next = cnt_reg - fenv_pkg::ITER_W'(1);
            if (cnt_reg == fenv_pkg::ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider reports done while still stepping");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider stepping with an empty iteration count");

endmodule

### rtl/fade_envelope_playback_sequencer.sv
// Fade envelope playback sequencer.
// Input channel (in_valid/in_ready, req_type, fade_frames): one transaction per
// audio frame tick, or a start or stop request carrying a fade length.
// Output channel (out_valid/out_ready): exactly one result transaction per
// input transaction, in order: read positions, Q1.15 gains, active flags,
// playing and ended.
// Configuration (cfg_we, cfg_index, cfg_data) writes one register per cycle;
// the user writes only while the block is idle; the block does not enforce it.
// One item at a time: in_ready is high only in the idle state. Start, stop
// and non-rendering ticks go from idle through the evaluate state to the done
// state, which loads the output register. A rendering tick adds, per active
// fade, the squares, a compare and, when needed, a divide of 15 quotient bits,
// then a divide of 24 remainder bits for the aux position and the gain steps.
// The result sits in an output register; the next item is accepted while it
// waits, and the sequencer stalls before loading a further result until
// out_ready takes the held one.
// Reset clears the playback state, restores the register defaults and leaves
// the block idle with no result pending.
module fade_envelope_playback_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fenv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fenv_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fenv_pkg::REQ_W-1:0]          req_type,
    input  logic [fenv_pkg::FADE_BITS-1:0]      fade_frames,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fenv_pkg::FRAME_BITS-1:0]     main_frame,
    output logic [fenv_pkg::FRAME_BITS-1:0]     aux_frame,
    output logic [fenv_pkg::GAIN_BITS-1:0]      main_gain,
    output logic [fenv_pkg::GAIN_BITS-1:0]      aux_gain,
    output logic                                main_active,
    output logic                                aux_active,
    output logic                                playing,
    output logic                                ended
);

    localparam int FB = fenv_pkg::FRAME_BITS;
    localparam int DB = fenv_pkg::FADE_BITS;
    localparam int GB = fenv_pkg::GAIN_BITS;

    fenv_pkg::cfg_t     cfg;
    fenv_pkg::div_ctl_t div_ctl;
    fenv_pkg::state_t   state_reg;
    fenv_pkg::state_t   state_next;

    logic [fenv_pkg::DEN_W-1:0]  div_rem_init;
    logic [fenv_pkg::DEN_W-1:0]  div_den;
    logic [FB-1:0]               div_dividend;
    logic                        div_done;
    logic [GB-1:0]               div_quot;
    logic [fenv_pkg::DEN_W-1:0]  div_rem;

    logic [fenv_pkg::MUL_W-1:0]  mul_a;
    logic [fenv_pkg::MUL_W-1:0]  mul_b;

    // playback state
    logic [FB-1:0] pos_reg, pos_next;
    logic [DB-1:0] fi_len_reg, fi_len_next;
    logic [DB-1:0] fi_cnt_reg, fi_cnt_next;
    logic [DB-1:0] fo_len_reg, fo_len_next;
    logic [DB-1:0] fo_cnt_reg, fo_cnt_next;
    logic          fading_reg, fading_next;
    logic          running_reg, running_next;

    // work registers
    logic [fenv_pkg::REQ_W-1:0]   req_reg, req_next;
    logic [DB-1:0]                fade_reg, fade_next;
    logic [fenv_pkg::FSUM_W-1:0]  frame_reg, frame_next;
    logic [GB-1:0]                fin_reg, fin_next;
    logic [GB-1:0]                fout_reg, fout_next;
    logic [fenv_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [fenv_pkg::PROD_W-1:0]  num_reg, num_next;
    logic                         phase_out_reg, phase_out_next;
    logic [FB-1:0]                r_main_frame_reg, r_main_frame_next;
    logic [FB-1:0]                r_aux_frame_reg, r_aux_frame_next;
    logic [GB-1:0]                r_main_gain_reg, r_main_gain_next;
    logic [GB-1:0]                r_aux_gain_reg, r_aux_gain_next;
    logic                         r_main_act_reg, r_main_act_next;
    logic                         r_aux_act_reg, r_aux_act_next;
    logic                         r_ended_reg, r_ended_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [FB-1:0] o_main_frame_reg, o_main_frame_next;
    logic [FB-1:0] o_aux_frame_reg, o_aux_frame_next;
    logic [GB-1:0] o_main_gain_reg, o_main_gain_next;
    logic [GB-1:0] o_aux_gain_reg, o_aux_gain_next;
    logic          o_main_act_reg, o_main_act_next;
    logic          o_aux_act_reg, o_aux_act_next;
    logic          o_playing_reg, o_playing_next;
    logic          o_ended_reg, o_ended_next;

    logic                         accept;
    logic                         out_free;
    logic                         track_ok;
    logic                         main_on;
    logic                         aux_on;
    logic [fenv_pkg::FSUM_W-1:0]  fo_sum;
    logic                         fo_past_end;
    logic [GB-1:0]                vol_sat;
    logic [GB-1:0]                base;
    logic [1:0]                   main_halve;
    logic [1:0]                   aux_halve;

    fenv_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fenv_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .rem_init  (div_rem_init),
        .den       (div_den),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        track_ok    = fenv_pkg::len_ok(cfg.track_length, cfg.block_frames);
        main_on     = !cfg.main_left[fenv_pkg::CHAN_W-1];
        aux_on      = !cfg.aux_left[fenv_pkg::CHAN_W-1]
                      && fenv_pkg::len_ok(cfg.aux_length, cfg.block_frames);
        fo_sum      = fenv_pkg::FSUM_W'(pos_reg) + fenv_pkg::FSUM_W'(fo_cnt_reg);
        fo_past_end = (fo_sum >= fenv_pkg::FSUM_W'(cfg.track_length));
        vol_sat     = (cfg.volume > fenv_pkg::GAIN_ONE) ? fenv_pkg::GAIN_ONE : cfg.volume;
        base        = GB'(prod_reg >> fenv_pkg::GAIN_FRAC);
        main_halve  = 2'(cfg.main_left == cfg.main_right)
                      + 2'(cfg.main_left == cfg.aux_left);
        aux_halve   = 2'(cfg.aux_left == cfg.aux_right)
                      + 2'(cfg.main_left == cfg.aux_left);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fenv_pkg::ST_IDLE:
                if (in_valid)
                    state_next = fenv_pkg::ST_EVAL;
            fenv_pkg::ST_EVAL:
                if (fenv_pkg::req_t'(req_reg) == fenv_pkg::REQ_TICK && running_reg
                    && track_ok && pos_reg < cfg.track_length)
                    state_next = (fi_cnt_reg < fi_len_reg) ? fenv_pkg::ST_SQ_CNT
                                                           : fenv_pkg::ST_FO_CHK;
                else
                    state_next = fenv_pkg::ST_DONE;
            fenv_pkg::ST_SQ_CNT:
                state_next = fenv_pkg::ST_SQ_LEN;
            fenv_pkg::ST_SQ_LEN:
                state_next = fenv_pkg::ST_CMP;
            fenv_pkg::ST_CMP:
                if (num_reg < prod_reg)
                    state_next = fenv_pkg::ST_DIV;
                else
                    state_next = phase_out_reg ? fenv_pkg::ST_MOD_GO : fenv_pkg::ST_FO_CHK;
            fenv_pkg::ST_DIV:
                if (div_done)
                    state_next = phase_out_reg ? fenv_pkg::ST_MOD_GO : fenv_pkg::ST_FO_CHK;
            fenv_pkg::ST_FO_CHK:
                if (!fading_reg)
                    state_next = fenv_pkg::ST_MOD_GO;
                else if (!fo_past_end && fo_cnt_reg < fo_len_reg)
                    state_next = fenv_pkg::ST_SQ_CNT;
                else
                    state_next = fenv_pkg::ST_DONE;
            fenv_pkg::ST_MOD_GO:
                state_next = aux_on ? fenv_pkg::ST_MOD : fenv_pkg::ST_GAIN_A;
            fenv_pkg::ST_MOD:
                if (div_done)
                    state_next = fenv_pkg::ST_GAIN_A;
            fenv_pkg::ST_GAIN_A:
                state_next = fenv_pkg::ST_GAIN_B;
            fenv_pkg::ST_GAIN_B:
                state_next = fenv_pkg::ST_GAIN_C;
            fenv_pkg::ST_GAIN_C:
                state_next = fenv_pkg::ST_DONE;
            fenv_pkg::ST_DONE:
                if (out_free)
                    state_next = fenv_pkg::ST_IDLE;
            default:
                state_next = fenv_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: unit controls and register updates
    always_comb
    begin
        in_ready          = (state_reg == fenv_pkg::ST_IDLE);
        div_ctl.start     = 1'b0;
        div_ctl.iters     = fenv_pkg::ITER_W'(fenv_pkg::GAIN_FRAC);
        div_rem_init      = fenv_pkg::DEN_W'(num_reg);
        div_den           = fenv_pkg::DEN_W'(prod_reg);
        div_dividend      = '0;
        mul_a             = fenv_pkg::MUL_W'(vol_sat);
        mul_b             = fenv_pkg::MUL_W'(fin_reg);

        pos_next          = pos_reg;
        fi_len_next       = fi_len_reg;
        fi_cnt_next       = fi_cnt_reg;
        fo_len_next       = fo_len_reg;
        fo_cnt_next       = fo_cnt_reg;
        fading_next       = fading_reg;
        running_next      = running_reg;
        req_next          = req_reg;
        fade_next         = fade_reg;
        frame_next        = frame_reg;
        fin_next          = fin_reg;
        fout_next         = fout_reg;
        num_next          = num_reg;
        phase_out_next    = phase_out_reg;
        r_main_frame_next = r_main_frame_reg;
        r_aux_frame_next  = r_aux_frame_reg;
        r_main_gain_next  = r_main_gain_reg;
        r_aux_gain_next   = r_aux_gain_reg;
        r_main_act_next   = r_main_act_reg;
        r_aux_act_next    = r_aux_act_reg;
        r_ended_next      = r_ended_reg;

        out_valid_next    = out_valid_reg && !out_ready;
        o_main_frame_next = o_main_frame_reg;
        o_aux_frame_next  = o_aux_frame_reg;
        o_main_gain_next  = o_main_gain_reg;
        o_aux_gain_next   = o_aux_gain_reg;
        o_main_act_next   = o_main_act_reg;
        o_aux_act_next    = o_aux_act_reg;
        o_playing_next    = o_playing_reg;
        o_ended_next      = o_ended_reg;

        case (state_reg)
            fenv_pkg::ST_IDLE:
                if (accept)
                begin
                    req_next  = req_type;
                    fade_next = fade_frames;
                end
            fenv_pkg::ST_EVAL:
            begin
                r_main_frame_next = '0;
                r_aux_frame_next  = '0;
                r_main_gain_next  = '0;
                r_aux_gain_next   = '0;
                r_main_act_next   = 1'b0;
                r_aux_act_next    = 1'b0;
                r_ended_next      = 1'b0;
                case (fenv_pkg::req_t'(req_reg))
                    fenv_pkg::REQ_START:
                        if (!running_reg)
                        begin
                            running_next = 1'b1;
                            fi_len_next  = fade_reg;
                            fi_cnt_next  = '0;
                        end
                    fenv_pkg::REQ_STOP:
                        if (running_reg && !fading_reg)
                        begin
                            fo_len_next = fade_reg;
                            fo_cnt_next = '0;
                            if (fade_reg == '0)
                            begin
                                running_next = 1'b0;
                                r_ended_next = 1'b1;
                            end
                            else
                                fading_next = 1'b1;
                        end
                    fenv_pkg::REQ_TICK:
                        if (running_reg)
                        begin
                            if (!track_ok || pos_reg >= cfg.track_length)
                            begin
                                if (track_ok)
                                    pos_next = '0;
                                fading_next  = 1'b0;
                                fo_len_next  = '0;
                                fo_cnt_next  = '0;
                                running_next = 1'b0;
                                r_ended_next = 1'b1;
                            end
                            else
                            begin
                                frame_next     = fenv_pkg::FSUM_W'(pos_reg);
                                fin_next       = fenv_pkg::GAIN_ONE;
                                fout_next      = fenv_pkg::GAIN_ONE;
                                phase_out_next = 1'b0;
                                if (fi_cnt_reg < fi_len_reg)
                                    fi_cnt_next = fi_cnt_reg + DB'(1);
                            end
                        end
                    default:
                        r_ended_next = 1'b0;
                endcase
            end
            fenv_pkg::ST_SQ_CNT:
            begin
                mul_a = phase_out_reg ? fenv_pkg::MUL_W'(fo_cnt_reg)
                                      : fenv_pkg::MUL_W'(fi_cnt_reg);
                mul_b = mul_a;
            end
            fenv_pkg::ST_SQ_LEN:
            begin
                mul_a    = phase_out_reg ? fenv_pkg::MUL_W'(fo_len_reg)
                                         : fenv_pkg::MUL_W'(fi_len_reg);
                mul_b    = mul_a;
                num_next = prod_reg;
            end
            fenv_pkg::ST_CMP:
                if (num_reg < prod_reg)
                    div_ctl.start = 1'b1;
                else if (phase_out_reg)
                    fout_next = '0;
                else
                    fin_next = fenv_pkg::GAIN_ONE;
            fenv_pkg::ST_DIV:
                if (div_done)
                begin
                    if (phase_out_reg)
                        fout_next = fenv_pkg::GAIN_ONE - div_quot;
                    else
                        fin_next = div_quot;
                end
            fenv_pkg::ST_FO_CHK:
                if (fading_reg)
                begin
                    frame_next = fo_sum;
                    if (!fo_past_end && fo_cnt_reg < fo_len_reg)
                    begin
                        fo_cnt_next    = fo_cnt_reg + DB'(1);
                        phase_out_next = 1'b1;
                    end
                    else
                    begin
                        fading_next  = 1'b0;
                        fo_len_next  = '0;
                        fo_cnt_next  = '0;
                        running_next = 1'b0;
                        r_ended_next = 1'b1;
                    end
                end
            fenv_pkg::ST_MOD_GO:
                if (aux_on)
                begin
                    div_ctl.start = 1'b1;
                    div_ctl.iters = fenv_pkg::ITER_W'(FB);
                    div_rem_init  = '0;
                    div_den       = fenv_pkg::DEN_W'(cfg.aux_length);
                    div_dividend  = frame_reg[FB-1:0];
                end
            fenv_pkg::ST_MOD:
                if (div_done)
                    r_aux_frame_next = div_rem[FB-1:0];
            fenv_pkg::ST_GAIN_B:
            begin
                mul_a = fenv_pkg::MUL_W'(prod_reg >> fenv_pkg::GAIN_FRAC);
                mul_b = fenv_pkg::MUL_W'(fout_reg);
            end
            fenv_pkg::ST_GAIN_C:
            begin
                r_main_frame_next = frame_reg[FB-1:0];
                r_main_gain_next  = main_on ? (base >> main_halve) : '0;
                r_aux_gain_next   = aux_on ? (base >> aux_halve) : '0;
                r_main_act_next   = main_on;
                r_aux_act_next    = aux_on;
                if (!fading_reg)
                    pos_next = pos_reg + FB'(1);
            end
            fenv_pkg::ST_DONE:
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    o_main_frame_next = r_main_frame_reg;
                    o_aux_frame_next  = r_aux_frame_reg;
                    o_main_gain_next  = r_main_gain_reg;
                    o_aux_gain_next   = r_aux_gain_reg;
                    o_main_act_next   = r_main_act_reg;
                    o_aux_act_next    = r_aux_act_reg;
                    o_playing_next    = running_reg;
                    o_ended_next      = r_ended_reg;
                end
            default:
                out_valid_next = out_valid_reg && !out_ready;
        endcase

        prod_next = fenv_pkg::PROD_W'(mul_a) * fenv_pkg::PROD_W'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fenv_pkg::ST_IDLE;
            pos_reg       <= '0;
            fi_len_reg    <= '0;
            fi_cnt_reg    <= '0;
            fo_len_reg    <= '0;
            fo_cnt_reg    <= '0;
            fading_reg    <= 1'b0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fi_len_reg    <= fi_len_next;
            fi_cnt_reg    <= fi_cnt_next;
            fo_len_reg    <= fo_len_next;
            fo_cnt_reg    <= fo_cnt_next;
            fading_reg    <= fading_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg          <= req_next;
        fade_reg         <= fade_next;
        frame_reg        <= frame_next;
        fin_reg          <= fin_next;
        fout_reg         <= fout_next;
        prod_reg         <= prod_next;
        num_reg          <= num_next;
        phase_out_reg    <= phase_out_next;
        r_main_frame_reg <= r_main_frame_next;
        r_aux_frame_reg  <= r_aux_frame_next;
        r_main_gain_reg  <= r_main_gain_next;
        r_aux_gain_reg   <= r_aux_gain_next;
        r_main_act_reg   <= r_main_act_next;
        r_aux_act_reg    <= r_aux_act_next;
        r_ended_reg      <= r_ended_next;
        o_main_frame_reg <= o_main_frame_next;
        o_aux_frame_reg  <= o_aux_frame_next;
        o_main_gain_reg  <= o_main_gain_next;
        o_aux_gain_reg   <= o_aux_gain_next;
        o_main_act_reg   <= o_main_act_next;
        o_aux_act_reg    <= o_aux_act_next;
        o_playing_reg    <= o_playing_next;
        o_ended_reg      <= o_ended_next;
    end

    assign out_valid   = out_valid_reg;
    assign main_frame  = o_main_frame_reg;
    assign aux_frame   = o_aux_frame_reg;
    assign main_gain   = o_main_gain_reg;
    assign aux_gain    = o_aux_gain_reg;
    assign main_active = o_main_act_reg;
    assign aux_active  = o_aux_act_reg;
    assign playing     = o_playing_reg;
    assign ended       = o_ended_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        fading_reg |-> running_reg)
        else $error("fade-out armed while playback is stopped");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fi_cnt_reg <= fi_len_reg) && (fo_cnt_reg <= fo_len_reg))
        else $error("fade count beyond its length");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == fenv_pkg::ST_DIV || state_reg == fenv_pkg::ST_MOD))
        else $error("divider finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_ended_reg) |-> !o_playing_reg)
        else $error("result reports ended while still playing");

endmodule

### bench/fade_envelope_playback_sequencer_tb.sv
module fade_envelope_playback_sequencer_tb;
    import fenv_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [REQ_W-1:0]     req;
        logic [FADE_BITS-1:0] fade;
    } play_req_t;

    typedef struct {
        logic [FRAME_BITS-1:0] main_frame;
        logic [FRAME_BITS-1:0] aux_frame;
        logic [GAIN_BITS-1:0]  main_gain;
        logic [GAIN_BITS-1:0]  aux_gain;
        logic                  main_active;
        logic                  aux_active;
        logic                  playing;
        logic                  ended;
    } frame_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type;
    logic [FADE_BITS-1:0]  fade_frames;
    logic                  out_valid;
    logic                  out_ready;
    logic [FRAME_BITS-1:0] main_frame;
    logic [FRAME_BITS-1:0] aux_frame;
    logic [GAIN_BITS-1:0]  main_gain;
    logic [GAIN_BITS-1:0]  aux_gain;
    logic                  main_active;
    logic                  aux_active;
    logic                  playing;
    logic                  ended;

    fade_envelope_playback_sequencer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .fade_frames (fade_frames),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .main_frame  (main_frame),
        .aux_frame   (aux_frame),
        .main_gain   (main_gain),
        .aux_gain    (aux_gain),
        .main_active (main_active),
        .aux_active  (aux_active),
        .playing     (playing),
        .ended       (ended)
    );

    // register copy
    logic [GAIN_BITS-1:0]  cfg_vol;
    logic signed [3:0]     cfg_ml;
    logic signed [3:0]     cfg_mr;
    logic signed [3:0]     cfg_al;
    logic signed [3:0]     cfg_ar;
    logic [FRAME_BITS-1:0] cfg_trk;
    logic [FRAME_BITS-1:0] cfg_aux;
    logic [BLOCK_W-1:0]    cfg_blk;

    // playback state
    logic [FRAME_BITS-1:0] pb_pos;
    logic [FADE_BITS-1:0]  fin_len;
    logic [FADE_BITS-1:0]  fin_cnt;
    logic [FADE_BITS-1:0]  fout_len;
    logic [FADE_BITS-1:0]  fout_cnt;
    logic                  pb_fading;
    logic                  pb_running;

    play_req_t  req_backlog[$];
    frame_out_t frame_outs_due[$];
    play_req_t  next_req;
    frame_out_t due;

    int queued_total   = 0;
    int mismatch_count = 0;
    int tx_odds        = 0;
    int rx_odds        = 0;
    int tx_gap         = 0;
    int rx_stall       = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    bit no_idle        = 1'b0;
    bit in_taken       = 1'b0;
    bit rdy_next;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint unsigned fade_curve(input longint unsigned c,
                                                   input longint unsigned l);
        longint unsigned num;
        longint unsigned den;
        num = c * c;
        den = l * l;
        if (num >= den)
            return longint'(GAIN_ONE);
        return (num << GAIN_FRAC) / den;
    endfunction

    function automatic bit len_usable(input logic [FRAME_BITS-1:0] len);
        return (len != '0) && (len >= cfg_blk);
    endfunction

    function automatic void end_playback();
        pb_fading  = 1'b0;
        fout_len   = '0;
        fout_cnt   = '0;
        pb_running = 1'b0;
    endfunction

    function automatic frame_out_t advance_playback(input logic [REQ_W-1:0]     req,
                                                    input logic [FADE_BITS-1:0] fade);
        frame_out_t      r;
        longint unsigned frame;
        longint unsigned vol;
        longint unsigned fin;
        longint unsigned fout;
        longint unsigned base;
        bit              stop_now;
        bit              main_on;
        bit              aux_on;
        int              mh;
        int              ah;
        r = '{default: '0};
        stop_now = 1'b0;
        mh = 0;
        ah = 0;
        case (req)
            REQ_START:
                if (!pb_running)
                begin
                    pb_running = 1'b1;
                    fin_len    = fade;
                    fin_cnt    = '0;
                end
            REQ_STOP:
                if (pb_running && !pb_fading)
                begin
                    pb_fading = 1'b1;
                    fout_len  = fade;
                    fout_cnt  = '0;
                    if (fade == '0)
                    begin
                        pb_fading  = 1'b0;
                        pb_running = 1'b0;
                        stop_now   = 1'b1;
                    end
                end
            REQ_TICK:
                if (pb_running)
                begin
                    if (!len_usable(cfg_trk))
                    begin
                        end_playback();
                        stop_now = 1'b1;
                    end
                    else if (pb_pos >= cfg_trk)
                    begin
                        pb_pos = '0;
                        end_playback();
                        stop_now = 1'b1;
                    end
                    else
                    begin
                        frame = pb_pos;
                        vol   = (cfg_vol > GAIN_ONE) ? GAIN_ONE : cfg_vol;
                        fin   = GAIN_ONE;
                        fout  = GAIN_ONE;
                        if (fin_cnt < fin_len)
                        begin
                            fin_cnt = fin_cnt + 1'b1;
                            fin = fade_curve(fin_cnt, fin_len);
                        end
                        if (pb_fading)
                        begin
                            frame = frame + fout_cnt;
                            if (frame >= cfg_trk)
                            begin
                                end_playback();
                                stop_now = 1'b1;
                            end
                            else if (fout_cnt < fout_len)
                            begin
                                fout_cnt = fout_cnt + 1'b1;
                                fout = GAIN_ONE - fade_curve(fout_cnt, fout_len);
                            end
                            else
                            begin
                                end_playback();
                                stop_now = 1'b1;
                            end
                        end
                        if (!stop_now)
                        begin
                            main_on = !cfg_ml[3];
                            aux_on  = !cfg_al[3] && len_usable(cfg_aux);
                            if (cfg_ml == cfg_mr)
                                mh++;
                            if (cfg_al == cfg_ar)
                                ah++;
                            if (cfg_ml == cfg_al)
                            begin
                                mh++;
                                ah++;
                            end
                            base = (((vol * fin) >> GAIN_FRAC) * fout) >> GAIN_FRAC;
                            r.main_frame = frame[FRAME_BITS-1:0];
                            if (aux_on)
                            begin
                                r.aux_frame = FRAME_BITS'(frame % cfg_aux);
                                r.aux_gain  = GAIN_BITS'(base >> ah);
                            end
                            if (main_on)
                                r.main_gain = GAIN_BITS'(base >> mh);
                            r.main_active = main_on;
                            r.aux_active  = aux_on;
                            if (!pb_fading)
                                pb_pos = pb_pos + 1'b1;
                        end
                    end
                end
            default:
                ;
        endcase
        r.playing = pb_running;
        r.ended   = stop_now;
        return r;
    endfunction

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                frame_outs_due.push_back(advance_playback(req_type, fade_frames));
                in_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                if (frame_outs_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: transaction expected none actual main_frame %0d",
                             $time, main_frame);
                end
                else
                begin
                    due = frame_outs_due.pop_front();
                    compare_field("main_frame", due.main_frame, main_frame);
                    compare_field("aux_frame", due.aux_frame, aux_frame);
                    compare_field("main_gain", due.main_gain, main_gain);
                    compare_field("aux_gain", due.aux_gain, aux_gain);
                    compare_field("main_active", due.main_active, main_active);
                    compare_field("aux_active", due.aux_active, aux_active);
                    compare_field("playing", due.playing, playing);
                    compare_field("ended", due.ended, ended);
                end
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (req_backlog.size() != 0 && !no_idle && tx_odds != 0
                     && $urandom_range(0, tx_odds) == 0)
            begin
                tx_gap = $urandom_range(1, 15) - 1;
                in_valid <= 1'b0;
            end
            else if (req_backlog.size() != 0)
            begin
                next_req = req_backlog.pop_front();
                in_valid    <= 1'b1;
                req_type    <= next_req.req;
                fade_frames <= next_req.fade;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rdy_next = 1'b0;
            if (hold_left > 0)
                hold_left--;
            else if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            else if (rx_stall > 0)
                rx_stall--;
            else if (!no_idle && rx_odds != 0 && $urandom_range(0, rx_odds) == 0)
                rx_stall = $urandom_range(1, 15) - 1;
            else
                rdy_next = 1'b1;
            out_ready <= rdy_next;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_VOLUME:       cfg_vol = val[GAIN_BITS-1:0];
            CFG_MAIN_LEFT:    cfg_ml  = val[3:0];
            CFG_MAIN_RIGHT:   cfg_mr  = val[3:0];
            CFG_AUX_LEFT:     cfg_al  = val[3:0];
            CFG_AUX_RIGHT:    cfg_ar  = val[3:0];
            CFG_TRACK_LENGTH: cfg_trk = val[FRAME_BITS-1:0];
            CFG_AUX_LENGTH:   cfg_aux = val[FRAME_BITS-1:0];
            CFG_BLOCK_FRAMES: cfg_blk = val[BLOCK_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic set_config(input logic [GAIN_BITS-1:0] vol, input logic signed [3:0] ml,
                              input logic signed [3:0] mr, input logic signed [3:0] al,
                              input logic signed [3:0] ar, input logic [FRAME_BITS-1:0] trk,
                              input logic [FRAME_BITS-1:0] aux, input logic [BLOCK_W-1:0] blk);
        write_reg(CFG_VOLUME, CFG_DATA_W'(vol));
        write_reg(CFG_MAIN_LEFT, CFG_DATA_W'($unsigned(ml)));
        write_reg(CFG_MAIN_RIGHT, CFG_DATA_W'($unsigned(mr)));
        write_reg(CFG_AUX_LEFT, CFG_DATA_W'($unsigned(al)));
        write_reg(CFG_AUX_RIGHT, CFG_DATA_W'($unsigned(ar)));
        write_reg(CFG_TRACK_LENGTH, CFG_DATA_W'(trk));
        write_reg(CFG_AUX_LENGTH, CFG_DATA_W'(aux));
        write_reg(CFG_BLOCK_FRAMES, CFG_DATA_W'(blk));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_req(input logic [REQ_W-1:0] req, input logic [FADE_BITS-1:0] fade);
        play_req_t r;
        r.req  = req;
        r.fade = fade;
        req_backlog.push_back(r);
        queued_total++;
    endtask

    function automatic logic [FADE_BITS-1:0] pick_fade();
        case ($urandom_range(0, 5))
            0:       return '0;
            1, 2:    return FADE_BITS'($urandom_range(1, 8));
            3:       return FADE_BITS'($urandom_range(9, 64));
            4:       return FADE_BITS'($urandom);
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [3:0] pick_chan();
        case ($urandom_range(0, 7))
            0:       return -4'sd1;
            1:       return -4'sd8;
            2:       return 4'sd7;
            default: return 4'($urandom_range(0, 2));
        endcase
    endfunction

    task automatic add_ticks(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 11) == 0)
                push_req(REQ_W'($urandom_range(0, 3)), FADE_BITS'($urandom));
            else
                push_req(REQ_TICK, FADE_BITS'($urandom));
        end
    endtask

    task automatic add_session();
        push_req(REQ_START, pick_fade());
        add_ticks($urandom_range(0, 40));
        if ($urandom_range(0, 3) != 0)
        begin
            push_req(REQ_STOP, pick_fade());
            add_ticks($urandom_range(0, 40));
        end
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || in_valid || frame_outs_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int                    p;
        int                    phase_start;
        logic [GAIN_BITS-1:0]  vol;
        logic [FRAME_BITS-1:0] trk;
        logic [FRAME_BITS-1:0] aux;
        logic [BLOCK_W-1:0]    blk;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_VOLUME;
        cfg_data    = '0;
        in_valid    = 1'b0;
        req_type    = REQ_TICK;
        fade_frames = '0;
        out_ready   = 1'b0;

        cfg_vol = GAIN_ONE;
        cfg_ml  = 4'sd0;
        cfg_mr  = 4'sd1;
        cfg_al  = 4'sd2;
        cfg_ar  = 4'sd3;
        cfg_trk = '0;
        cfg_aux = '0;
        cfg_blk = BLOCK_W'(256);
        pb_pos     = '0;
        fin_len    = '0;
        fin_cnt    = '0;
        fout_len   = '0;
        fout_cnt   = '0;
        pb_fading  = 1'b0;
        pb_running = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle tick, then a start against an empty track
        push_req(REQ_TICK, '0);
        push_req(REQ_START, '0);
        push_req(REQ_TICK, '1);
        wait_idle();

        // coinciding channels, volume above unity
        set_config('1, 4'sd0, 4'sd0, 4'sd0, 4'sd1, FRAME_BITS'(20), FRAME_BITS'(7),
                   BLOCK_W'(16));
        push_req(REQ_START, '1);
        push_req(REQ_START, FADE_BITS'(3));
        push_req(REQ_TICK, '0);
        push_req(REQ_TICK, '0);
        push_req(REQ_UNUSED, FADE_BITS'(20'hAAAAA));
        push_req(REQ_STOP, FADE_BITS'(2));
        push_req(REQ_TICK, '0);
        push_req(REQ_TICK, '0);
        push_req(REQ_TICK, '0);
        push_req(REQ_STOP, FADE_BITS'(5));
        push_req(REQ_START, '0);
        push_req(REQ_STOP, '0);
        push_req(REQ_START, FADE_BITS'(2));
        push_req(REQ_TICK, '0);
        push_req(REQ_STOP, '1);
        push_req(REQ_STOP, FADE_BITS'(1));
        push_req(REQ_TICK, '0);
        push_req(REQ_TICK, FADE_BITS'(20'h55555));
        push_req(REQ_UNUSED, '1);

        p = 0;
        while (queued_total < 1270)
        begin
            p++;
            wait_idle();
            tx_odds = (p % 3 == 0) ? 0 : $urandom_range(2, 8);
            rx_odds = (p % 4 == 1) ? 0 : $urandom_range(2, 8);
            if (queued_total >= 1050)
                no_idle = 1'b1;

            if (p == 1)
                blk = BLOCK_W'(4096);
            else if (p == 2 || $urandom_range(0, 3) != 0)
                blk = BLOCK_W'($urandom_range(16, 40));
            else
                blk = BLOCK_W'($urandom_range(16, 4096));

            if (p == 1)
                trk = '1;
            else
                case ($urandom_range(0, 7))
                    0:       trk = '0;
                    1:       trk = FRAME_BITS'(blk) - 1'b1;
                    default: trk = FRAME_BITS'(blk) + FRAME_BITS'($urandom_range(0, 48));
                endcase

            if (p == 1)
                aux = '1;
            else
                case ($urandom_range(0, 5))
                    0:       aux = '0;
                    1:       aux = '1;
                    2:       aux = FRAME_BITS'($urandom_range(1, blk - 1));
                    default: aux = FRAME_BITS'($urandom_range(blk, blk + 40));
                endcase

            if (p == 1)
                vol = '1;
            else if (p == 2)
                vol = '0;
            else
                case ($urandom_range(0, 4))
                    0:       vol = '0;
                    1:       vol = GAIN_ONE;
                    2:       vol = GAIN_BITS'($urandom);
                    default: vol = GAIN_BITS'($urandom_range(0, 32768));
                endcase

            if (p == 1)
                set_config(vol, 4'sd7, 4'sd7, 4'sd7, 4'sd7, trk, aux, blk);
            else
                set_config(vol, pick_chan(), pick_chan(), pick_chan(), pick_chan(),
                           trk, aux, blk);

            phase_start = queued_total;
            while (queued_total - phase_start < 140)
                add_session();
            // hold the output off so that the block backs up
            if (p == 2)
                hold_req++;
        end

        wait_idle();
        repeat (100) @(negedge clk);
        if (mismatch_count == 0 && frame_outs_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
